// ===== hw/rtl/rgb_window_mask_centroid_defines.svh =====
// Assertion macros shared by the colour window centroid RTL.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef RGB_WINDOW_MASK_CENTROID_DEFINES_SVH
`define RGB_WINDOW_MASK_CENTROID_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define RWMC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property that must hold in the cycle after a trigger.
`define RWMC_ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);
`else
`define RWMC_ASSERT(label, clk, rst, prop, msg)
`define RWMC_ASSERT_NEXT(label, clk, rst, trig, prop, msg)
`endif
`endif

// ===== hw/rtl/rwmc_pkg.sv =====
// Shared constants and types for the colour window centroid block.
// No dependencies; the RTL modules import this package and the channel interfaces refer to it.
`timescale 1ns / 1ps
package rwmc_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int COORD_BITS_DEF = 16;
  localparam int COLOUR_BITS    = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 8;
  localparam int QUEUE_DEPTH    = 4;
  localparam int SENTINEL_MM    = -1000;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLE    = 3'd0,
    REG_RED_MIN   = 3'd1,
    REG_RED_MAX   = 3'd2,
    REG_GREEN_MIN = 3'd3,
    REG_GREEN_MAX = 3'd4,
    REG_BLUE_MIN  = 3'd5,
    REG_BLUE_MAX  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [COLOUR_BITS-1:0] red;
    logic [COLOUR_BITS-1:0] green;
    logic [COLOUR_BITS-1:0] blue;
  } rgb_t;

  // Classification flags carried with each point through the queue.
  typedef struct packed {
    logic acc;
    logic last;
    logic enable;
  } entry_ctl_t;

  localparam int ENTRY_FIXED_BITS = $bits(rgb_t) + $bits(entry_ctl_t);

endpackage

// ===== hw/rtl/rwmc_point_if.sv =====
// Point input channel: valid/ready handshake with one coloured point per beat.
// Depends on rwmc_pkg for the default coordinate width.
`timescale 1ns / 1ps
interface rwmc_point_if #(
  parameter int COORD_BITS = rwmc_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic [7:0]                   red_in;
  logic [7:0]                   green_in;
  logic [7:0]                   blue_in;
  logic                         cloud_end;

  modport source (
    output valid, coord_x, coord_y, coord_z, red_in, green_in, blue_in, cloud_end,
    input  ready
  );
  modport sink (
    input  valid, coord_x, coord_y, coord_z, red_in, green_in, blue_in, cloud_end,
    output ready
  );
endinterface

// ===== hw/rtl/rwmc_result_if.sv =====
// Result output channel: valid/ready handshake with one masked point per beat.
// Depends on rwmc_pkg for the default coordinate width.
`timescale 1ns / 1ps
interface rwmc_result_if #(
  parameter int COORD_BITS = rwmc_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [7:0]                   red_out;
  logic [7:0]                   green_out;
  logic [7:0]                   blue_out;
  logic                         centroid_ready;
  logic                         target_found;
  logic signed [COORD_BITS-1:0] centroid_x;
  logic signed [COORD_BITS-1:0] centroid_y;
  logic signed [COORD_BITS-1:0] centroid_z;

  modport source (
    output valid, red_out, green_out, blue_out, centroid_ready, target_found,
           centroid_x, centroid_y, centroid_z,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, centroid_ready, target_found,
           centroid_x, centroid_y, centroid_z,
    output ready
  );
endinterface

// ===== hw/rtl/rgb_window_mask_centroid.sv =====
// Top level of the colour window segmentation and centroid block.
// Depends on rwmc_pkg, both channel interfaces, rwmc_front, rwmc_queue and rwmc_back.
//
//   Port        Direction  Beat contents
//   points      in         coordinates, colour and end-of-cloud flag of one point
//   results     out        masked colour, centroid flags and centroid of the cloud
//   cfg_*       in         register write: enable and six colour window limits
//
// An ordinary point goes from the queue straight into the result register, so points
// stream at one per cycle while results are taken and the back end is idle.
// The last point of a cloud holds the back end while a restoring divider finds one
// quotient bit a cycle, all axes at once. A cloud with no passed point, or ended with
// filtering off, skips the divider. A four-entry queue lets the front accept points meanwhile.
// Reset is synchronous and clears the registers, the sums, the queue and the result valid.
`timescale 1ns / 1ps
module rgb_window_mask_centroid #(
  parameter int COUNT_BITS = rwmc_pkg::COUNT_BITS_DEF,
  parameter int COORD_BITS = rwmc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rwmc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rwmc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  rwmc_point_if.sink                          points,
  rwmc_result_if.source                       results
);
  import rwmc_pkg::*;

  localparam int ENTRY_BITS = 3 * COORD_BITS + ENTRY_FIXED_BITS;

  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  logic [ENTRY_BITS-1:0] q_wr_data;
  logic [ENTRY_BITS-1:0] q_rd_data;

  // Classification of each point against the colour window.
  rwmc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .points    (points),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  // Decoupling queue between classifier and accumulator.
  rwmc_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Accumulation, centroid division and result register.
  rwmc_back #(
    .COUNT_BITS (COUNT_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_rd_data),
    .results (results)
  );

endmodule

// ===== hw/rtl/rwmc_queue.sv =====
// Short first-in first-out queue between the classifier and the accumulator.
// Depends on rwmc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "rgb_window_mask_centroid_defines.svh"
module rwmc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rwmc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import rwmc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  `RWMC_ASSERT(a_no_push_full, clk, rst, push |-> !full, "queue written while full")
  `RWMC_ASSERT(a_no_pop_empty, clk, rst, pop |-> !empty, "queue read while empty")
  `RWMC_ASSERT_NEXT(a_count_track, clk, rst, push && !pop, count == $past(count) + 1'b1, "fill level lost a write")

endmodule

// ===== hw/rtl/rwmc_front.sv =====
// Front end: configuration registers and colour window classification of each point.
// Depends on rwmc_pkg and the point channel interface.
`timescale 1ns / 1ps
module rwmc_front #(
  parameter int COORD_BITS = rwmc_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [rwmc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [rwmc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  rwmc_point_if.sink                              points,
  input  logic                                    q_full,
  output logic                                    q_push,
  output logic [3*COORD_BITS+rwmc_pkg::ENTRY_FIXED_BITS-1:0] q_data
);
  import rwmc_pkg::*;

  logic       enable;
  rgb_t       win_min;
  rgb_t       win_max;
  logic       pass;
  rgb_t       rgb_masked;
  entry_ctl_t ctl;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b0;
      win_min <= '0;
      win_max <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ENABLE:    enable        <= cfg_data[0];
        REG_RED_MIN:   win_min.red   <= cfg_data;
        REG_RED_MAX:   win_max.red   <= cfg_data;
        REG_GREEN_MIN: win_min.green <= cfg_data;
        REG_GREEN_MAX: win_max.green <= cfg_data;
        REG_BLUE_MIN:  win_min.blue  <= cfg_data;
        REG_BLUE_MAX:  win_max.blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Inclusive window test on all three channels.
  assign pass = (points.red_in   >= win_min.red)   && (points.red_in   <= win_max.red)   &&
                (points.green_in >= win_min.green) && (points.green_in <= win_max.green) &&
                (points.blue_in  >= win_min.blue)  && (points.blue_in  <= win_max.blue);

  // A rejected point turns black while filtering is on.
  always_comb begin
    rgb_masked = '{red: points.red_in, green: points.green_in, blue: points.blue_in};
    if (enable && !pass) begin
      rgb_masked = '0;
    end
  end

  assign ctl = '{acc: enable && pass, last: points.cloud_end, enable: enable};

  assign points.ready = !q_full;
  assign q_push       = points.valid && !q_full;
  assign q_data       = {points.coord_x, points.coord_y, points.coord_z, rgb_masked, ctl};

endmodule

// ===== hw/rtl/rwmc_back.sv =====
// Back end: coordinate sums, the per-cloud divider and the result register.
// Depends on rwmc_pkg, the result channel interface and the assertion macros.
`timescale 1ns / 1ps
`include "rgb_window_mask_centroid_defines.svh"
module rwmc_back #(
  parameter int COUNT_BITS = rwmc_pkg::COUNT_BITS_DEF,
  parameter int COORD_BITS = rwmc_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_empty,
  output logic                                    q_pop,
  input  logic [3*COORD_BITS+rwmc_pkg::ENTRY_FIXED_BITS-1:0] q_data,
  rwmc_result_if.source                           results
);
  import rwmc_pkg::*;

  localparam int SUM_BITS = COORD_BITS + COUNT_BITS + 1;
  localparam int CNT_W    = COUNT_BITS + 1;
  localparam int REM_W    = COUNT_BITS + 2;
  localparam int STEP_W   = $clog2(SUM_BITS + 1);
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(1) << COUNT_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } back_state_t;

  back_state_t                  state;
  logic signed [COORD_BITS-1:0] ent_coord [3];
  rgb_t                         ent_rgb;
  entry_ctl_t                   ent_ctl;

  logic signed [SUM_BITS-1:0]   sum_acc [3];
  logic [CNT_W-1:0]             passed_count;
  logic                         out_valid;
  logic                         out_free;
  logic                         out_load;
  logic                         found_c;

  // Divider and pending-result registers.
  logic [SUM_BITS-1:0]          quo [3];
  logic [REM_W-1:0]             rem [3];
  logic                         neg [3];
  logic [STEP_W-1:0]            step;
  logic                         found;
  logic                         last_en;
  rgb_t                         pend_rgb;

  logic [SUM_BITS-1:0]          mag [3];
  logic [REM_W-1:0]             trial [3];
  logic                         ge [3];
  logic [COORD_BITS-1:0]        q_lo [3];
  logic [COORD_BITS-1:0]        cen_val [3];

  // Result register payload.
  rgb_t                         out_rgb;
  logic                         out_cready;
  logic                         out_found;
  logic [COORD_BITS-1:0]        out_cen [3];

  assign {ent_coord[0], ent_coord[1], ent_coord[2], ent_rgb, ent_ctl} = q_data;

  assign out_free = !out_valid || results.ready;
  assign q_pop    = (state == S_IDLE) && !q_empty && out_free;
  assign found_c  = last_en && (passed_count != '0);
  // A new beat enters the result register for an ordinary point or a finished cloud.
  assign out_load = (q_pop && !ent_ctl.last) || ((state == S_FIN) && out_free);

  // Per-axis magnitude, restoring divide step and signed centroid.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]     = sum_acc[k][SUM_BITS-1] ? SUM_BITS'(-sum_acc[k]) : SUM_BITS'(sum_acc[k]);
      trial[k]   = {rem[k][REM_W-2:0], quo[k][SUM_BITS-1]};
      ge[k]      = trial[k] >= REM_W'(passed_count);
      q_lo[k]    = quo[k][COORD_BITS-1:0];
      cen_val[k] = found ? (neg[k] ? -q_lo[k] : q_lo[k]) : COORD_BITS'(SENTINEL_MM);
    end
  end

  // Control: sequencer, accumulators and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      passed_count <= '0;
      for (int k = 0; k < 3; k++) begin
        sum_acc[k] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            // Points past the saturated count keep colour but are not summed.
            if (ent_ctl.acc && !passed_count[COUNT_BITS]) begin
              for (int k = 0; k < 3; k++) begin
                sum_acc[k] <= sum_acc[k] + SUM_BITS'(ent_coord[k]);
              end
              passed_count <= passed_count + 1'b1;
            end
            if (ent_ctl.last) begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          state <= found_c ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (step == STEP_W'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            passed_count <= '0;
            for (int k = 0; k < 3; k++) begin
              sum_acc[k] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: divider iterations and result payload.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && q_pop) begin
      if (ent_ctl.last) begin
        pend_rgb <= ent_rgb;
        last_en  <= ent_ctl.enable;
      end else begin
        out_rgb    <= ent_rgb;
        out_cready <= 1'b0;
        out_found  <= 1'b0;
        for (int k = 0; k < 3; k++) begin
          out_cen[k] <= '0;
        end
      end
    end
    if (state == S_LOAD) begin
      found <= found_c;
      step  <= STEP_W'(SUM_BITS);
      for (int k = 0; k < 3; k++) begin
        neg[k] <= sum_acc[k][SUM_BITS-1];
        quo[k] <= mag[k];
        rem[k] <= '0;
      end
    end
    if (state == S_DIV) begin
      step <= step - 1'b1;
      for (int k = 0; k < 3; k++) begin
        quo[k] <= {quo[k][SUM_BITS-2:0], ge[k]};
        rem[k] <= ge[k] ? trial[k] - REM_W'(passed_count) : trial[k];
      end
    end
    if ((state == S_FIN) && out_free) begin
      out_rgb    <= pend_rgb;
      out_cready <= 1'b1;
      out_found  <= found;
      for (int k = 0; k < 3; k++) begin
        out_cen[k] <= cen_val[k];
      end
    end
  end

  assign results.valid          = out_valid;
  assign results.red_out        = out_rgb.red;
  assign results.green_out      = out_rgb.green;
  assign results.blue_out       = out_rgb.blue;
  assign results.centroid_ready = out_cready;
  assign results.target_found   = out_found;
  assign results.centroid_x     = out_cen[0];
  assign results.centroid_y     = out_cen[1];
  assign results.centroid_z     = out_cen[2];

  `RWMC_ASSERT(a_pop_idle, clk, rst, q_pop |-> (state == S_IDLE), "queue read outside idle")
  `RWMC_ASSERT(a_count_bound, clk, rst, passed_count <= COUNT_MAX, "count beyond saturation")
  `RWMC_ASSERT(a_div_step, clk, rst, (state == S_DIV) |-> (step != '0), "divider ran out of steps")
  `RWMC_ASSERT_NEXT(a_clear_after_cloud, clk, rst, (state == S_FIN) && out_free, (passed_count == '0) && (state == S_IDLE), "accumulators not cleared after cloud")

endmodule

// ===== tb/sv/rgb_window_mask_centroid_tb.sv =====
// Self-checking testbench for rgb_window_mask_centroid: colour window masking and cloud centroid.
// Needs rwmc_pkg, rwmc_point_if, rwmc_result_if and the block's RTL; nothing else.
`timescale 1ns / 1ps
module rgb_window_mask_centroid_tb;
  import rwmc_pkg::*;

  localparam int CW           = COORD_BITS_DEF;
  localparam int NBITS        = COUNT_BITS_DEF;
  localparam int POINT_GOAL   = 1750;
  localparam int GAP_MAX      = 17;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PRINT_CAP    = 100;
  // Index past the last register; writes to it must change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 last;
  } point_t;

  typedef struct {
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 done;
    logic                 found;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } result_t;

  // Mirror of the block: register copy, running sums and the beats still owed.
  class centroid_scoreboard;
    logic       enable;
    logic [7:0] lo [3];
    logic [7:0] hi [3];
    longint     sum_x, sum_y, sum_z;
    longint     passed;
    result_t    awaited [$];
    int         errors;
    int         beats_seen;

    function new();
      enable = 1'b0;
      for (int c = 0; c < 3; c++) begin
        lo[c] = '0;
        hi[c] = '0;
      end
      clear_sums();
      errors     = 0;
      beats_seen = 0;
    endfunction

    function void clear_sums();
      sum_x  = 0;
      sum_y  = 0;
      sum_z  = 0;
      passed = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [7:0] data);
      case (idx)
        REG_ENABLE:    enable = data[0];
        REG_RED_MIN:   lo[0]  = data;
        REG_RED_MAX:   hi[0]  = data;
        REG_GREEN_MIN: lo[1]  = data;
        REG_GREEN_MAX: hi[1]  = data;
        REG_BLUE_MIN:  lo[2]  = data;
        REG_BLUE_MAX:  hi[2]  = data;
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      // Keep the log readable once things go badly wrong.
      if (errors <= PRINT_CAP) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // Work out the beat that an accepted point must produce.
    function void note_point(point_t p);
      result_t    e;
      logic [7:0] col [3];
      logic       pass;
      longint     cx, cy, cz;
      col[0] = p.red;
      col[1] = p.green;
      col[2] = p.blue;
      if (enable) begin
        pass = 1'b1;
        for (int c = 0; c < 3; c++)
          if (col[c] < lo[c] || col[c] > hi[c]) pass = 1'b0;
        if (pass) begin
          // The count saturates; points past it keep colour but are not summed.
          if (passed < (longint'(1) << NBITS)) begin
            sum_x += longint'(p.x);
            sum_y += longint'(p.y);
            sum_z += longint'(p.z);
            passed++;
          end
        end else begin
          for (int c = 0; c < 3; c++) col[c] = '0;
        end
      end
      e.red   = col[0];
      e.green = col[1];
      e.blue  = col[2];
      e.done  = p.last;
      e.found = 1'b0;
      e.cx    = '0;
      e.cy    = '0;
      e.cz    = '0;
      if (p.last) begin
        e.found = enable && (passed != 0);
        cx = SENTINEL_MM;
        cy = SENTINEL_MM;
        cz = SENTINEL_MM;
        if (e.found) begin
          // Signed division truncates toward zero, as the block must.
          cx = sum_x / passed;
          cy = sum_y / passed;
          cz = sum_z / passed;
        end
        e.cx = cx[CW-1:0];
        e.cy = cy[CW-1:0];
        e.cz = cz[CW-1:0];
        clear_sums();
      end
      awaited.push_back(e);
    endfunction

    task check_result(result_t got);
      result_t want;
      beats_seen++;
      if (awaited.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing expected", beats_seen));
        return;
      end
      want = awaited.pop_front();
      if (got.red !== want.red)
        report($sformatf("beat %0d red_out %0d, expected %0d", beats_seen, got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("beat %0d green_out %0d, expected %0d", beats_seen, got.green,
                         want.green));
      if (got.blue !== want.blue)
        report($sformatf("beat %0d blue_out %0d, expected %0d", beats_seen, got.blue,
                         want.blue));
      if (got.done !== want.done)
        report($sformatf("beat %0d centroid_ready %b, expected %b", beats_seen, got.done,
                         want.done));
      if (got.found !== want.found)
        report($sformatf("beat %0d target_found %b, expected %b", beats_seen, got.found,
                         want.found));
      if (got.cx !== want.cx)
        report($sformatf("beat %0d centroid_x %0d, expected %0d", beats_seen, got.cx, want.cx));
      if (got.cy !== want.cy)
        report($sformatf("beat %0d centroid_y %0d, expected %0d", beats_seen, got.cy, want.cy));
      if (got.cz !== want.cz)
        report($sformatf("beat %0d centroid_z %0d, expected %0d", beats_seen, got.cz, want.cz));
    endtask

    task finish_check();
      if (awaited.size() != 0)
        report($sformatf("%0d result beats never arrived", awaited.size()));
    endtask
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  rwmc_point_if  #(.COORD_BITS(CW)) point_bus ();
  rwmc_result_if #(.COORD_BITS(CW)) result_bus ();

  rgb_window_mask_centroid #(
    .COUNT_BITS(NBITS),
    .COORD_BITS(CW)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .points   (point_bus),
    .results  (result_bus)
  );

  centroid_scoreboard sb = new();
  idle_mode_t src_mode  = IDLE_SOME;
  idle_mode_t sink_mode = IDLE_SOME;
  int         sent      = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap before the next beat, shaped by the current idling mode.
  function automatic int draw_gap(idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, GAP_MAX) : 0;
      default:   return $urandom_range(0, GAP_MAX);
    endcase
  endfunction

  function automatic point_t mk_point(int x, int y, int z, int r, int g, int b, bit last);
    point_t p;
    p.x     = x[CW-1:0];
    p.y     = y[CW-1:0];
    p.z     = z[CW-1:0];
    p.red   = r[7:0];
    p.green = g[7:0];
    p.blue  = b[7:0];
    p.last  = last;
    return p;
  endfunction

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(CW-1){1'b1}}};
      1:       return {1'b1, {(CW-1){1'b0}}};
      2:       return CW'(int'($urandom_range(0, 200)) - 100);
      default: return CW'($urandom);
    endcase
  endfunction

  // Mostly inside the window so that clouds gather real sums.
  function automatic logic [7:0] pick_colour(logic [7:0] lo, logic [7:0] hi);
    if (lo <= hi && $urandom_range(0, 99) < 70) return 8'($urandom_range(hi, lo));
    return 8'($urandom);
  endfunction

  // Send one point beat; returns at the falling edge after it was taken.
  task automatic send_point(point_t p);
    int gap;
    gap = draw_gap(src_mode);
    if (gap > 0) begin
      point_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_bus.valid     = 1'b1;
    point_bus.coord_x   = p.x;
    point_bus.coord_y   = p.y;
    point_bus.coord_z   = p.z;
    point_bus.red_in    = p.red;
    point_bus.green_in  = p.green;
    point_bus.blue_in   = p.blue;
    point_bus.cloud_end = p.last;
    @(posedge clk);
    while (!point_bus.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every owed beat has come back.
  task automatic wait_drained();
    point_bus.valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [7:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.set_reg(idx, data);
  endtask

  // One colour window, biased toward the extremes and the empty case.
  task automatic random_window(logic [CFG_INDEX_BITS-1:0] lo_idx,
                               logic [CFG_INDEX_BITS-1:0] hi_idx);
    logic [7:0] a, b, t;
    case ($urandom_range(0, 9))
      0: begin a = 8'd0;   b = 8'd255; end
      1: begin a = 8'($urandom_range(1, 255)); b = 8'($urandom_range(0, a - 1)); end
      2: begin a = 8'($urandom); b = a; end
      3: begin a = 8'd0;   b = 8'd0;   end
      4: begin a = 8'd255; b = 8'd255; end
      default: begin
        a = 8'($urandom);
        b = 8'($urandom);
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
      end
    endcase
    write_reg(lo_idx, a);
    write_reg(hi_idx, b);
  endtask

  // Receiver: draws a stall before each beat, then takes it.
  initial begin
    int hold;
    result_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      hold = draw_gap(sink_mode);
      if (hold > 0) begin
        result_bus.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      result_bus.ready = 1'b1;
      @(posedge clk);
      while (result_bus.valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  // Monitor: inputs are noted before results are checked within an edge.
  always @(posedge clk) begin
    point_t  pt;
    result_t rs;
    if (!rst && point_bus.valid && point_bus.ready) begin
      pt.x     = point_bus.coord_x;
      pt.y     = point_bus.coord_y;
      pt.z     = point_bus.coord_z;
      pt.red   = point_bus.red_in;
      pt.green = point_bus.green_in;
      pt.blue  = point_bus.blue_in;
      pt.last  = point_bus.cloud_end;
      sb.note_point(pt);
    end
    if (!rst && result_bus.valid && result_bus.ready) begin
      rs.red   = result_bus.red_out;
      rs.green = result_bus.green_out;
      rs.blue  = result_bus.blue_out;
      rs.done  = result_bus.centroid_ready;
      rs.found = result_bus.target_found;
      rs.cx    = result_bus.centroid_x;
      rs.cy    = result_bus.centroid_y;
      rs.cz    = result_bus.centroid_z;
      sb.check_result(rs);
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((point_bus.valid && point_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("rgb_window_mask_centroid_tb: FAIL");
    $finish;
  end

  initial begin
    point_t p;
    int     clouds, size;
    logic   en, leave_open;

    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = REG_ENABLE;
    cfg_data            = '0;
    point_bus.valid     = 1'b0;
    point_bus.coord_x   = '0;
    point_bus.coord_y   = '0;
    point_bus.coord_z   = '0;
    point_bus.red_in    = '0;
    point_bus.green_in  = '0;
    point_bus.blue_in   = '0;
    point_bus.cloud_end = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Out of reset the block is disabled: colours pass, the centroid is the sentinel.
    src_mode  = IDLE_NONE;
    sink_mode = IDLE_SOME;
    send_point(mk_point(100, -200, 300, 12, 34, 56, 0));
    send_point(mk_point(-32768, 32767, 0, 255, 0, 255, 1));

    // Full windows: coordinate extremes and truncation of a negative mean.
    wait_drained();
    write_reg(REG_ENABLE, 8'd1);
    write_reg(REG_RED_MIN, 8'd0);
    write_reg(REG_RED_MAX, 8'd255);
    write_reg(REG_GREEN_MIN, 8'd0);
    write_reg(REG_GREEN_MAX, 8'd255);
    write_reg(REG_BLUE_MIN, 8'd0);
    write_reg(REG_BLUE_MAX, 8'd255);
    send_point(mk_point(32767, -32768, -7, 0, 0, 0, 0));
    send_point(mk_point(32767, -32768, 0, 255, 255, 255, 1));
    // A single accepted point that sits exactly on the sentinel value.
    send_point(mk_point(-1000, -1000, -1000, 1, 2, 3, 1));

    // Window edges: just outside, on, and inside each limit.
    wait_drained();
    write_reg(REG_RED_MIN, 8'd10);
    write_reg(REG_RED_MAX, 8'd20);
    write_reg(REG_GREEN_MIN, 8'd5);
    write_reg(REG_GREEN_MAX, 8'd5);
    write_reg(REG_BLUE_MIN, 8'd250);
    write_reg(REG_BLUE_MAX, 8'd255);
    send_point(mk_point(1, 1, 1, 9, 5, 250, 0));
    send_point(mk_point(2, 2, 2, 10, 5, 255, 0));
    send_point(mk_point(4, -3, 6, 20, 5, 250, 0));
    send_point(mk_point(9, 9, 9, 21, 5, 250, 0));
    send_point(mk_point(9, 9, 9, 15, 4, 250, 0));
    send_point(mk_point(9, 9, 9, 15, 6, 250, 0));
    send_point(mk_point(9, 9, 9, 15, 5, 249, 1));

    // Empty green window blacks out everything; the spare index is ignored.
    wait_drained();
    write_reg(REG_GREEN_MIN, 8'd200);
    write_reg(REG_GREEN_MAX, 8'd100);
    write_reg(REG_SPARE, 8'hFF);
    send_point(mk_point(5, 5, 5, 15, 150, 250, 0));
    send_point(mk_point(5, 5, 5, 15, 200, 250, 1));

    // Enable dropped and restored within one cloud: only enabled points count.
    wait_drained();
    write_reg(REG_GREEN_MIN, 8'd0);
    write_reg(REG_GREEN_MAX, 8'd255);
    send_point(mk_point(100, 200, 300, 15, 77, 251, 0));
    wait_drained();
    write_reg(REG_ENABLE, 8'd0);
    send_point(mk_point(500, 500, 500, 15, 77, 251, 0));
    wait_drained();
    write_reg(REG_ENABLE, 8'd1);
    send_point(mk_point(-100, -200, -300, 16, 78, 252, 1));

    // Disabled on the last point: sentinel, and the sums are still cleared.
    send_point(mk_point(40, 40, 40, 16, 78, 252, 0));
    wait_drained();
    write_reg(REG_ENABLE, 8'hFE);
    send_point(mk_point(0, 0, 0, 16, 78, 252, 1));
    wait_drained();
    write_reg(REG_ENABLE, 8'd1);
    send_point(mk_point(8, 8, 8, 16, 78, 252, 1));

    // Random phases: fresh settings, then a run of clouds with random content.
    while (sent < POINT_GOAL) begin
      wait_drained();
      src_mode  = idle_mode_t'($urandom_range(0, 2));
      sink_mode = idle_mode_t'($urandom_range(0, 2));
      en = ($urandom_range(0, 4) != 0);
      write_reg(REG_ENABLE, {7'($urandom), en});
      random_window(REG_RED_MIN, REG_RED_MAX);
      random_window(REG_GREEN_MIN, REG_GREEN_MAX);
      random_window(REG_BLUE_MIN, REG_BLUE_MAX);
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 8'($urandom));
      clouds = $urandom_range(2, 8);
      for (int k = 0; k < clouds; k++) begin
        size = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
        // Now and then a cloud runs on into the next phase's settings.
        leave_open = (k == clouds - 1) && ($urandom_range(0, 3) == 0);
        for (int j = 0; j < size; j++) begin
          if ($urandom_range(0, 59) == 0) wait_drained();
          p.x     = pick_coord();
          p.y     = pick_coord();
          p.z     = pick_coord();
          p.red   = pick_colour(sb.lo[0], sb.hi[0]);
          p.green = pick_colour(sb.lo[1], sb.hi[1]);
          p.blue  = pick_colour(sb.lo[2], sb.hi[2]);
          p.last  = (j == size - 1) && !leave_open;
          // A stray end flag breaks a cloud early.
          if ($urandom_range(0, 49) == 0) p.last = 1'b1;
          send_point(p);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.finish_check();
    if (sb.errors == 0)
      $display("rgb_window_mask_centroid_tb: PASS");
    else
      $display("rgb_window_mask_centroid_tb: FAIL");
    $finish;
  end

endmodule
